FILE: rtl/hll_pkg.sv
// ----------------------------------------------------------------------------
// hll_pkg
// shared widths and types for the hyperloglog insert block
// ----------------------------------------------------------------------------
package hll_pkg;

    localparam int HASH_W = 64;
    localparam int RANK_W = 6;

    typedef struct packed {
        logic              clearing;
        logic [RANK_W-1:0] min_rank;
    } t_status;

endpackage

FILE: rtl/hll_front.sv
// ----------------------------------------------------------------------------
// hll_front
// accepts hashes, derives register index and rank, flags possible raises
// ----------------------------------------------------------------------------
module hll_front #(
    parameter int PRECISION_BITS
) (
    input  logic                          push,
    output logic                          full,
    input  logic [hll_pkg::HASH_W-1:0]    i_hash,
    input  hll_pkg::t_status              i_status,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output logic [PRECISION_BITS-1:0]     o_q_idx,
    output logic [hll_pkg::RANK_W-1:0]    o_q_rank,
    output logic                          o_q_cand
);

    localparam int SHIFT_BITS = hll_pkg::HASH_W - PRECISION_BITS;
    localparam int NBYTES     = hll_pkg::HASH_W / 8;
    localparam int TCNT_W     = $clog2(hll_pkg::HASH_W + 1);

    function automatic logic [TCNT_W-1:0] f_trail_ones(input logic [hll_pkg::HASH_W-1:0] h);
        logic [3:0]        bcnt;
        logic              brun;
        logic [TCNT_W-1:0] total;
        logic              run;
        int                b;
        int                k;
        total = '0;
        run   = 1'b1;
        for (b = 0; b < NBYTES; b++) begin
            bcnt = '0;
            brun = 1'b1;
            for (k = 0; k < 8; k++) begin
                if (brun && h[8*b+k]) begin
                    bcnt = bcnt + 4'd1;
                end else begin
                    brun = 1'b0;
                end
            end
            if (run) begin
                total = total + TCNT_W'(bcnt);
            end
            run = run & (&h[8*b +: 8]);
        end
        return total;
    endfunction

    logic [TCNT_W-1:0]          trail;
    logic [TCNT_W-1:0]          capped;
    logic [hll_pkg::HASH_W-1:0] filter;

    always_comb begin
        trail  = f_trail_ones(i_hash);
        capped = (trail > TCNT_W'(SHIFT_BITS)) ? TCNT_W'(SHIFT_BITS) : trail;
        filter = {hll_pkg::HASH_W{1'b1}} << i_status.min_rank;
    end

    assign full     = i_q_full || i_status.clearing;
    assign o_q_push = push && !full;
    assign o_q_idx  = i_hash[hll_pkg::HASH_W-1 -: PRECISION_BITS];
    assign o_q_rank = hll_pkg::RANK_W'(capped) + hll_pkg::RANK_W'(1);
    assign o_q_cand = &(filter | i_hash);

endmodule

FILE: rtl/hll_queue.sv
// ----------------------------------------------------------------------------
// hll_queue
// two-entry queue of classified words between front and back
// ----------------------------------------------------------------------------
module hll_queue #(
    parameter int WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/hll_back.sv
// ----------------------------------------------------------------------------
// hll_back
// register store read-modify-write, value histogram and minimum walk
// ----------------------------------------------------------------------------
module hll_back #(
    parameter int PRECISION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    input  logic [PRECISION_BITS-1:0]     i_q_idx,
    input  logic [hll_pkg::RANK_W-1:0]    i_q_rank,
    input  logic                          i_q_cand,
    output hll_pkg::t_status              o_status,
    input  logic                          pop,
    output logic                          empty,
    output logic                          o_updated,
    output logic [PRECISION_BITS-1:0]     o_register_index,
    output logic [hll_pkg::RANK_W-1:0]    o_old_rank,
    output logic [hll_pkg::RANK_W-1:0]    o_new_rank,
    output logic [hll_pkg::RANK_W-1:0]    o_min_rank
);

    localparam int RW       = hll_pkg::RANK_W;
    localparam int NREGS    = 1 << PRECISION_BITS;
    localparam int MAX_RANK = hll_pkg::HASH_W - PRECISION_BITS + 1;
    localparam int HDEPTH   = MAX_RANK + 1;
    localparam int HA_W     = $clog2(HDEPTH);
    localparam int CNT_W    = PRECISION_BITS + 1;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_HDEC  = 6'b001000,
        ST_HINC  = 6'b010000,
        ST_WALK  = 6'b100000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [PRECISION_BITS-1:0] r_clr_idx;
    logic [PRECISION_BITS-1:0] r_idx;
    logic [RW-1:0]             r_rank;
    logic                      r_cand;
    logic [RW-1:0]             r_rd;
    logic [RW-1:0]             r_min;
    logic [HDEPTH-1:0]         r_nz;
    logic                      r_h0_wr;
    logic [CNT_W-1:0]          r_hc_old;
    logic [CNT_W-1:0]          r_hc_new;
    logic                      r_walk;
    logic                      r_ov;
    logic                      r_upd;
    logic [PRECISION_BITS-1:0] r_oidx;
    logic [RW-1:0]             r_oold;
    logic [RW-1:0]             r_onew;
    logic [RW-1:0]             r_omin;

    logic [RW-1:0]             rank_mem [NREGS];
    logic [CNT_W-1:0]          hist_mem [HDEPTH];

    logic                      take;
    logic                      raise;
    logic [HA_W-1:0]           old_a;
    logic [HA_W-1:0]           new_a;
    logic [HA_W-1:0]           min_a;
    logic [CNT_W-1:0]          eff_old;
    logic [CNT_W-1:0]          dec;
    logic [CNT_W-1:0]          inc;
    logic                      walk_more;
    logic                      finish;
    logic                      rank_we;
    logic [PRECISION_BITS-1:0] rank_wa;
    logic [RW-1:0]             rank_wd;
    logic                      hist_we;
    logic [HA_W-1:0]           hist_wa;
    logic [CNT_W-1:0]          hist_wd;

    always_comb begin
        take    = (r_state == ST_IDLE) && !i_q_empty && (!r_ov || pop);
        raise   = r_cand && (r_rd < r_rank);
        old_a   = r_rd[HA_W-1:0];
        new_a   = r_rank[HA_W-1:0];
        min_a   = r_min[HA_W-1:0];
        if (!r_nz[old_a]) begin
            eff_old = '0;
        end else if ((old_a == '0) && !r_h0_wr) begin
            eff_old = CNT_W'(NREGS);
        end else begin
            eff_old = r_hc_old;
        end
        dec       = (eff_old != '0) ? eff_old - 1'b1 : '0;
        inc       = (r_nz[new_a] ? r_hc_new : '0) + 1'b1;
        walk_more = (r_min < RW'(MAX_RANK)) && !r_nz[min_a];
        finish    = ((r_state == ST_READ) && !raise) ||
                    ((r_state == ST_HINC) && !r_walk) ||
                    ((r_state == ST_WALK) && !walk_more);
        rank_we   = (r_state == ST_CLEAR) || ((r_state == ST_READ) && raise);
        rank_wa   = (r_state == ST_CLEAR) ? r_clr_idx : r_idx;
        rank_wd   = (r_state == ST_CLEAR) ? '0 : r_rank;
        hist_we   = (r_state == ST_HDEC) || (r_state == ST_HINC);
        hist_wa   = (r_state == ST_HDEC) ? old_a : new_a;
        hist_wd   = (r_state == ST_HDEC) ? dec : inc;
    end

    always_comb begin
        case (r_state)
            ST_CLEAR: n_state = (r_clr_idx == {PRECISION_BITS{1'b1}}) ? ST_IDLE : ST_CLEAR;
            ST_IDLE:  n_state = take ? ST_READ : ST_IDLE;
            ST_READ:  n_state = raise ? ST_HDEC : ST_IDLE;
            ST_HDEC:  n_state = ST_HINC;
            ST_HINC:  n_state = r_walk ? ST_WALK : ST_IDLE;
            ST_WALK:  n_state = walk_more ? ST_WALK : ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // register store and histogram memories
    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            rank_mem[rank_wa] <= rank_wd;
        end
        if (take) begin
            r_rd <= rank_mem[i_q_idx];
        end
        if (hist_we) begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (r_state == ST_READ) begin
            r_hc_old <= hist_mem[old_a];
            r_hc_new <= hist_mem[new_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_min     <= '0;
            r_nz      <= HDEPTH'(1);
            r_h0_wr   <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == ST_HDEC) begin
                r_nz[old_a] <= (dec != '0);
                if (old_a == '0) begin
                    r_h0_wr <= 1'b1;
                end
            end
            if (r_state == ST_HINC) begin
                r_nz[new_a] <= 1'b1;
            end
            if ((r_state == ST_WALK) && walk_more) begin
                r_min <= r_min + 1'b1;
            end
            if (finish) begin
                r_ov <= 1'b1;
            end else if (pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_idx  <= i_q_idx;
            r_rank <= i_q_rank;
            r_cand <= i_q_cand;
        end
        if (r_state == ST_HDEC) begin
            r_walk <= (dec == '0) && (r_rd == r_min);
        end
        if (finish) begin
            r_upd  <= (r_state != ST_READ);
            r_oidx <= r_idx;
            r_oold <= r_rd;
            r_onew <= (r_state != ST_READ) ? r_rank : r_rd;
            r_omin <= r_min;
        end
    end

    assign o_q_pop           = take;
    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_status.min_rank = r_min;
    assign empty             = !r_ov;
    assign o_updated         = r_upd;
    assign o_register_index  = r_oidx;
    assign o_old_rank        = r_oold;
    assign o_new_rank        = r_onew;
    assign o_min_rank        = r_omin;

    a_upd_raises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_updated) |-> (o_new_rank > o_old_rank))
        else $error("updated word does not raise the rank");

    a_noupd_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_updated) |-> (o_new_rank == o_old_rank))
        else $error("word without update changes the rank");

    a_min_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |-> (r_min <= RW'(MAX_RANK)))
        else $error("minimum rank beyond cap");

    a_min_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |-> (r_min >= $past(r_min)))
        else $error("minimum rank went down");

    a_min_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> r_nz[min_a])
        else $error("minimum rank bin is empty");

endmodule

FILE: rtl/hll_sketch_insert.sv
// ----------------------------------------------------------------------------
// hll_sketch_insert
// hyperloglog register insert with value histogram and running minimum
// ----------------------------------------------------------------------------
// After reset the block clears its 2^PRECISION_BITS register store, one entry
// a cycle, and holds full high while it clears. In the back stage a hash that
// does not raise its register goes through the store read and then the result;
// a hash that raises it goes through the store read, the store write and the
// histogram decrement and increment. When the minimum rank advances, the walk
// steps over each empty histogram bin and stops at an occupied bin or the cap.
// The register store and histogram memories are read through registers. The
// front classifies and queues up to two hashes while the back stage or the
// result register is busy; the back stage takes its next hash only once the
// previous result word has been popped or is popped in that cycle.
module hll_sketch_insert #(
    parameter int PRECISION_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [hll_pkg::HASH_W-1:0]    i_hash,
    input  logic                          pop,
    output logic                          empty,
    output logic                          o_updated,
    output logic [PRECISION_BITS-1:0]     o_register_index,
    output logic [hll_pkg::RANK_W-1:0]    o_old_rank,
    output logic [hll_pkg::RANK_W-1:0]    o_new_rank,
    output logic [hll_pkg::RANK_W-1:0]    o_min_rank
);

    localparam int QW = PRECISION_BITS + hll_pkg::RANK_W + 1;

    hll_pkg::t_status                status;
    logic                            q_push;
    logic                            q_full;
    logic                            q_pop;
    logic                            q_empty;
    logic [PRECISION_BITS-1:0]       f_idx;
    logic [hll_pkg::RANK_W-1:0]      f_rank;
    logic                            f_cand;
    logic [PRECISION_BITS-1:0]       b_idx;
    logic [hll_pkg::RANK_W-1:0]      b_rank;
    logic                            b_cand;
    logic [QW-1:0]                   q_wdata;
    logic [QW-1:0]                   q_rdata;

    hll_front #(
        .PRECISION_BITS (PRECISION_BITS)
    ) u_front (
        .push     (push),
        .full     (full),
        .i_hash   (i_hash),
        .i_status (status),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_idx  (f_idx),
        .o_q_rank (f_rank),
        .o_q_cand (f_cand)
    );

    assign q_wdata = {f_idx, f_rank, f_cand};

    hll_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign {b_idx, b_rank, b_cand} = q_rdata;

    hll_back #(
        .PRECISION_BITS (PRECISION_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .i_q_idx          (b_idx),
        .i_q_rank         (b_rank),
        .i_q_cand         (b_cand),
        .o_status         (status),
        .pop              (pop),
        .empty            (empty),
        .o_updated        (o_updated),
        .o_register_index (o_register_index),
        .o_old_rank       (o_old_rank),
        .o_new_rank       (o_new_rank),
        .o_min_rank       (o_min_rank)
    );

endmodule
